@@ rtl/core/ert_pkg.sv @@
// shared types, constants and tables for the euler rotate/translate point unit
`timescale 1ns / 1ps
`default_nettype none
package ert_pkg;

   localparam int COORD_W     = 32;                 // Q16.16 coordinates
   localparam int ANGLE_W     = 16;                 // Q3.13 angles
   localparam int COEF_W      = 32;                 // Q.30 sin/cos, Q.28 matrix entries
   localparam int Z_W         = 35;                 // Q.30 angle accumulator
   localparam int ANGLE_SHIFT = 17;                 // Q3.13 -> Q.30
   localparam int DIFF_W      = COORD_W + 1;
   localparam int PROD_W      = COEF_W + DIFF_W;
   localparam int SUM_W       = PROD_W + 2;
   localparam int ACC_W       = 2 * COEF_W;
   localparam int OUT_SHIFT   = 28;

   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_ENTRIES = 24;
   localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
   localparam int ITER_W       = (CORDIC_ITERS > 1) ? $clog2(CORDIC_ITERS) : 1;
   localparam int ATAN_IDX_W   = $clog2(ATAN_ENTRIES);

   localparam logic signed [COEF_W-1:0] GAIN_Q30    = 32'sd652032874;
   localparam logic signed [Z_W-1:0]    HALF_PI_Q30 = 35'sd1686629713;
   localparam logic signed [Z_W-1:0]    PI_Q30      = 35'sd3373259426;

   localparam int NUM_OPS = 14;
   localparam int OP_W    = $clog2(NUM_OPS);

   typedef logic [2:0][ANGLE_W-1:0] angles_type;
   typedef logic [2:0][COEF_W-1:0]  trig_type;
   typedef logic [8:0][COEF_W-1:0]  matrix_type;

   typedef enum logic [2:0] {
      CSR_ANGLE_X = 3'd0,
      CSR_ANGLE_Y = 3'd1,
      CSR_ANGLE_Z = 3'd2,
      CSR_PIVOT_X = 3'd3,
      CSR_PIVOT_Y = 3'd4,
      CSR_PIVOT_Z = 3'd5
   } csr_idx_type;

   typedef enum logic [2:0] {
      SRC_SX, SRC_CX, SRC_SY, SRC_CY, SRC_SZ, SRC_CZ, SRC_SXSY, SRC_SYCX
   } src_type;

   typedef enum logic [3:0] {
      DST_NONE, DST_SXSY, DST_SYCX, DST_M00, DST_M01, DST_M10, DST_M11,
      DST_M12, DST_M20, DST_M21, DST_M22
   } dst_type;

   typedef struct packed {
      src_type src_a;
      src_type src_b;
      logic    neg;
      logic    accum;
      dst_type dst;
   } op_type;

   typedef enum logic [2:0] {
      COEF_IDLE, COEF_LOAD, COEF_WAIT, COEF_MULT, COEF_DRAIN
   } coef_state_type;

   function automatic logic signed [Z_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
      logic signed [Z_W-1:0] v;
      unique case (idx)
         5'd0:  v = 35'sd843314856;
         5'd1:  v = 35'sd497837829;
         5'd2:  v = 35'sd263043836;
         5'd3:  v = 35'sd133525158;
         5'd4:  v = 35'sd67021686;
         5'd5:  v = 35'sd33543515;
         5'd6:  v = 35'sd16775850;
         5'd7:  v = 35'sd8388437;
         5'd8:  v = 35'sd4194282;
         5'd9:  v = 35'sd2097149;
         5'd10: v = 35'sd1048575;
         5'd11: v = 35'sd524287;
         5'd12: v = 35'sd262143;
         5'd13: v = 35'sd131071;
         5'd14: v = 35'sd65535;
         5'd15: v = 35'sd32767;
         5'd16: v = 35'sd16383;
         5'd17: v = 35'sd8191;
         5'd18: v = 35'sd4095;
         5'd19: v = 35'sd2047;
         5'd20: v = 35'sd1023;
         5'd21: v = 35'sd511;
         5'd22: v = 35'sd255;
         5'd23: v = 35'sd127;
         default: v = '0;
      endcase
      return v;
   endfunction

   // multiply program for the matrix entries, two products per summed entry
   function automatic op_type coef_op(input logic [OP_W-1:0] idx);
      op_type o;
      unique case (idx)
         4'd0:  o = '{SRC_SX,   SRC_SY, 1'b0, 1'b0, DST_SXSY};
         4'd1:  o = '{SRC_CX,   SRC_SY, 1'b0, 1'b0, DST_SYCX};
         4'd2:  o = '{SRC_CY,   SRC_CZ, 1'b0, 1'b0, DST_M00};
         4'd3:  o = '{SRC_CY,   SRC_SZ, 1'b1, 1'b0, DST_M01};
         4'd4:  o = '{SRC_SXSY, SRC_CZ, 1'b1, 1'b0, DST_NONE};
         4'd5:  o = '{SRC_CX,   SRC_SZ, 1'b0, 1'b1, DST_M10};
         4'd6:  o = '{SRC_SXSY, SRC_SZ, 1'b0, 1'b0, DST_NONE};
         4'd7:  o = '{SRC_CX,   SRC_CZ, 1'b0, 1'b1, DST_M11};
         4'd8:  o = '{SRC_SX,   SRC_CY, 1'b1, 1'b0, DST_M12};
         4'd9:  o = '{SRC_SYCX, SRC_CZ, 1'b0, 1'b0, DST_NONE};
         4'd10: o = '{SRC_SX,   SRC_SZ, 1'b0, 1'b1, DST_M20};
         4'd11: o = '{SRC_SYCX, SRC_SZ, 1'b1, 1'b0, DST_NONE};
         4'd12: o = '{SRC_SX,   SRC_CZ, 1'b0, 1'b1, DST_M21};
         4'd13: o = '{SRC_CX,   SRC_CY, 1'b0, 1'b0, DST_M22};
         default: o = '{SRC_SX, SRC_SX, 1'b0, 1'b0, DST_NONE};
      endcase
      return o;
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/ert_cordic.sv @@
// three-lane iterative rotation-mode cordic giving sin and cos of the angles
`timescale 1ns / 1ps
`default_nettype none
module ert_cordic (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire ert_pkg::angles_type angles,
   output logic                     done,
   output ert_pkg::trig_type        sin_q30,
   output ert_pkg::trig_type        cos_q30
);

   localparam logic [ert_pkg::ITER_W-1:0] LAST_ITER = ert_pkg::ITER_W'(ert_pkg::CORDIC_ITERS - 1);

   logic                               run_ff, run_in;
   logic                               done_ff, done_in;
   logic [ert_pkg::ITER_W-1:0]         cnt_ff, cnt_in;
   logic signed [ert_pkg::COEF_W-1:0]  x_ff [3];
   logic signed [ert_pkg::COEF_W-1:0]  x_in [3];
   logic signed [ert_pkg::COEF_W-1:0]  y_ff [3];
   logic signed [ert_pkg::COEF_W-1:0]  y_in [3];
   logic signed [ert_pkg::Z_W-1:0]     z_ff [3];
   logic signed [ert_pkg::Z_W-1:0]     z_in [3];
   logic [2:0]                         neg_ff, neg_in;
   logic signed [ert_pkg::Z_W-1:0]     z0;
   logic signed [ert_pkg::Z_W-1:0]     atan_v;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      z0      = '0;
      atan_v  = ert_pkg::atan_q30(ert_pkg::ATAN_IDX_W'(cnt_ff));
      for (int l = 0; l < 3; l++) begin
         x_in[l] = x_ff[l];
         y_in[l] = y_ff[l];
         z_in[l] = z_ff[l];
      end
      if (load) begin
         run_in = 1'b1;
         cnt_in = '0;
         for (int l = 0; l < 3; l++) begin
            z0 = ert_pkg::Z_W'($signed(angles[l])) <<< ert_pkg::ANGLE_SHIFT;
            x_in[l] = ert_pkg::GAIN_Q30;
            y_in[l] = '0;
            // fold into the right half plane, flip the signs at the end
            if (z0 > ert_pkg::HALF_PI_Q30) begin
               z_in[l]   = z0 - ert_pkg::PI_Q30;
               neg_in[l] = 1'b1;
            end else if (z0 < -ert_pkg::HALF_PI_Q30) begin
               z_in[l]   = z0 + ert_pkg::PI_Q30;
               neg_in[l] = 1'b1;
            end else begin
               z_in[l]   = z0;
               neg_in[l] = 1'b0;
            end
         end
      end else if (run_ff) begin
         for (int l = 0; l < 3; l++) begin
            if (z_ff[l] >= 0) begin
               x_in[l] = x_ff[l] - (y_ff[l] >>> cnt_ff);
               y_in[l] = y_ff[l] + (x_ff[l] >>> cnt_ff);
               z_in[l] = z_ff[l] - atan_v;
            end else begin
               x_in[l] = x_ff[l] + (y_ff[l] >>> cnt_ff);
               y_in[l] = y_ff[l] - (x_ff[l] >>> cnt_ff);
               z_in[l] = z_ff[l] + atan_v;
            end
         end
         if (cnt_ff == LAST_ITER) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      neg_ff <= neg_in;
      for (int l = 0; l < 3; l++) begin
         x_ff[l] <= x_in[l];
         y_ff[l] <= y_in[l];
         z_ff[l] <= z_in[l];
      end
   end

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         cos_q30[l] = neg_ff[l] ? -x_ff[l] : x_ff[l];
         sin_q30[l] = neg_ff[l] ? -y_ff[l] : y_ff[l];
      end
   end

   assign done = done_ff;

endmodule
`default_nettype wire

@@ rtl/core/ert_coef.sv @@
// rotation matrix builder: cordic then a shared multiply-accumulate sequencer
`timescale 1ns / 1ps
`default_nettype none
module ert_coef (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                kick,
   input  wire ert_pkg::angles_type angles,
   output logic                     busy,
   output ert_pkg::matrix_type      matrix
);

   localparam logic [ert_pkg::OP_W-1:0] LAST_OP = ert_pkg::OP_W'(ert_pkg::NUM_OPS - 1);

   ert_pkg::coef_state_type           state_ff, state_in;
   logic                              pending_ff;
   logic [ert_pkg::OP_W-1:0]          op_cnt_ff, op_cnt_in;
   logic                              acc_v_ff;
   ert_pkg::op_type                   opq_ff, op_cur;
   logic signed [ert_pkg::ACC_W-1:0]  prod_ff, acc_ff, acc_in;
   logic signed [ert_pkg::COEF_W-1:0] sxsy_ff, sycx_ff;
   logic signed [ert_pkg::COEF_W-1:0] m_ff [9];
   logic signed [ert_pkg::COEF_W-1:0] opa, opb;
   logic signed [ert_pkg::ACC_W-1:0]  rnd30, rnd32;
   logic signed [ert_pkg::COEF_W-1:0] neg_sy;
   logic                              cordic_done;
   ert_pkg::trig_type                 sin_q30, cos_q30;

   ert_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .load    (state_ff == ert_pkg::COEF_LOAD),
      .angles  (angles),
      .done    (cordic_done),
      .sin_q30 (sin_q30),
      .cos_q30 (cos_q30)
   );

   function automatic logic signed [ert_pkg::COEF_W-1:0] pick(
      input ert_pkg::src_type   s,
      input ert_pkg::trig_type  sn,
      input ert_pkg::trig_type  cs,
      input logic [ert_pkg::COEF_W-1:0] sxsy,
      input logic [ert_pkg::COEF_W-1:0] sycx
   );
      logic [ert_pkg::COEF_W-1:0] v;
      unique case (s)
         ert_pkg::SRC_SX:   v = sn[0];
         ert_pkg::SRC_CX:   v = cs[0];
         ert_pkg::SRC_SY:   v = sn[1];
         ert_pkg::SRC_CY:   v = cs[1];
         ert_pkg::SRC_SZ:   v = sn[2];
         ert_pkg::SRC_CZ:   v = cs[2];
         ert_pkg::SRC_SXSY: v = sxsy;
         ert_pkg::SRC_SYCX: v = sycx;
         default:           v = '0;
      endcase
      return $signed(v);
   endfunction

   always_comb begin
      state_in  = state_ff;
      op_cnt_in = op_cnt_ff;
      if (kick || pending_ff) begin
         state_in = ert_pkg::COEF_LOAD;
      end else begin
         unique case (state_ff)
            ert_pkg::COEF_LOAD: state_in = ert_pkg::COEF_WAIT;
            ert_pkg::COEF_WAIT: begin
               if (cordic_done) begin
                  state_in  = ert_pkg::COEF_MULT;
                  op_cnt_in = '0;
               end
            end
            ert_pkg::COEF_MULT: begin
               if (op_cnt_ff == LAST_OP) state_in = ert_pkg::COEF_DRAIN;
               else op_cnt_in = op_cnt_ff + 1'b1;
            end
            ert_pkg::COEF_DRAIN: state_in = ert_pkg::COEF_IDLE;
            ert_pkg::COEF_IDLE:  state_in = ert_pkg::COEF_IDLE;
            default:             state_in = ert_pkg::COEF_IDLE;
         endcase
      end
   end

   always_comb begin
      op_cur = ert_pkg::coef_op(op_cnt_ff);
      opa    = pick(op_cur.src_a, sin_q30, cos_q30, sxsy_ff, sycx_ff);
      opb    = pick(op_cur.src_b, sin_q30, cos_q30, sxsy_ff, sycx_ff);
      acc_in = (opq_ff.accum ? acc_ff : '0) + (opq_ff.neg ? -prod_ff : prod_ff);
      rnd30  = (acc_in + (ert_pkg::ACC_W'(1) <<< 29)) >>> 30;
      rnd32  = (acc_in + (ert_pkg::ACC_W'(1) <<< 31)) >>> 32;
      neg_sy = -$signed(sin_q30[1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ert_pkg::COEF_IDLE;
         pending_ff <= 1'b1;
         op_cnt_ff  <= '0;
         acc_v_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pending_ff <= 1'b0;
         op_cnt_ff  <= op_cnt_in;
         acc_v_ff   <= (state_ff == ert_pkg::COEF_MULT);
      end
      prod_ff <= ert_pkg::ACC_W'(opa) * ert_pkg::ACC_W'(opb);
      opq_ff  <= op_cur;
      // entry (0,2) is just the negated sine of y in Q.28
      if (state_ff == ert_pkg::COEF_WAIT && cordic_done) begin
         m_ff[2] <= (neg_sy + ert_pkg::COEF_W'(2)) >>> 2;
      end
      if (acc_v_ff) begin
         acc_ff <= acc_in;
         unique case (opq_ff.dst)
            ert_pkg::DST_NONE: ;
            ert_pkg::DST_SXSY: sxsy_ff <= rnd30[ert_pkg::COEF_W-1:0];
            ert_pkg::DST_SYCX: sycx_ff <= rnd30[ert_pkg::COEF_W-1:0];
            ert_pkg::DST_M00:  m_ff[0] <= rnd32[ert_pkg::COEF_W-1:0];
            ert_pkg::DST_M01:  m_ff[1] <= rnd32[ert_pkg::COEF_W-1:0];
            ert_pkg::DST_M10:  m_ff[3] <= rnd32[ert_pkg::COEF_W-1:0];
            ert_pkg::DST_M11:  m_ff[4] <= rnd32[ert_pkg::COEF_W-1:0];
            ert_pkg::DST_M12:  m_ff[5] <= rnd32[ert_pkg::COEF_W-1:0];
            ert_pkg::DST_M20:  m_ff[6] <= rnd32[ert_pkg::COEF_W-1:0];
            ert_pkg::DST_M21:  m_ff[7] <= rnd32[ert_pkg::COEF_W-1:0];
            ert_pkg::DST_M22:  m_ff[8] <= rnd32[ert_pkg::COEF_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int k = 0; k < 9; k++) matrix[k] = m_ff[k];
   end

   assign busy = (state_ff != ert_pkg::COEF_IDLE) || pending_ff;

endmodule
`default_nettype wire

@@ rtl/core/ert_xform.sv @@
// four-stage point pipeline: subtract pivot, multiply, sum and round, saturate
`timescale 1ns / 1ps
`default_nettype none
module ert_xform (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   input  wire logic [2:0][ert_pkg::COORD_W-1:0]  point,
   input  wire logic [2:0][ert_pkg::COORD_W-1:0]  pivot,
   input  wire ert_pkg::matrix_type               matrix,
   output logic                                   out_valid,
   output logic [2:0][ert_pkg::COORD_W-1:0]       out_coord,
   output logic                                   out_sat
);

   localparam logic signed [ert_pkg::SUM_W-1:0] RND_HALF = ert_pkg::SUM_W'(1) <<< (ert_pkg::OUT_SHIFT - 1);
   localparam logic signed [ert_pkg::SUM_W-1:0] SAT_MAX  = ert_pkg::SUM_W'(32'sh7fffffff);
   localparam logic signed [ert_pkg::SUM_W-1:0] SAT_MIN  = ert_pkg::SUM_W'(-33'sh80000000);

   logic                               v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [ert_pkg::DIFF_W-1:0]  d_ff [3];
   logic signed [ert_pkg::PROD_W-1:0]  p_ff [9];
   logic signed [ert_pkg::SUM_W-1:0]   s_ff [3];
   logic signed [ert_pkg::SUM_W-1:0]   sh [3];
   logic [2:0][ert_pkg::COORD_W-1:0]   o_in;
   logic [2:0][ert_pkg::COORD_W-1:0]   o_ff;
   logic [2:0]                         sat_v;
   logic                               sat_ff;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         sh[r] = s_ff[r] >>> ert_pkg::OUT_SHIFT;
         sat_v[r] = 1'b1;
         if (sh[r] > SAT_MAX)      o_in[r] = 32'h7fffffff;
         else if (sh[r] < SAT_MIN) o_in[r] = 32'h80000000;
         else begin
            o_in[r]  = sh[r][ert_pkg::COORD_W-1:0];
            sat_v[r] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      for (int c = 0; c < 3; c++) begin
         d_ff[c] <= ert_pkg::DIFF_W'($signed(point[c])) - ert_pkg::DIFF_W'($signed(pivot[c]));
      end
      for (int k = 0; k < 9; k++) begin
         p_ff[k] <= ert_pkg::PROD_W'($signed(matrix[k])) * ert_pkg::PROD_W'(d_ff[k % 3]);
      end
      for (int r = 0; r < 3; r++) begin
         s_ff[r] <= ert_pkg::SUM_W'(p_ff[3*r]) + ert_pkg::SUM_W'(p_ff[3*r+1])
                  + ert_pkg::SUM_W'(p_ff[3*r+2]) + RND_HALF;
      end
      o_ff   <= o_in;
      sat_ff <= |sat_v;
   end

   assign out_valid = v4_ff;
   assign out_coord = o_ff;
   assign out_sat   = sat_ff;

endmodule
`default_nettype wire

@@ rtl/core/euler_rotate_translate_point_unit.sv @@
// top level: config registers, coefficient builder and point pipeline
`timescale 1ns / 1ps
`default_nettype none
// Rotates each point about the pivot by the three Euler angles. One point is taken per clock
// while busy is low, and its word appears on the rsp_ ports after the pivot, multiply, sum and
// saturate registers, one per cycle, with rsp_valid high for exactly one cycle; the receiver
// cannot stall. After reset and after every angle write, busy stays high while the three-lane
// cordic runs CORDIC_STEPS iterations and the shared multiplier works through fourteen
// products for the matrix. Pivot writes take effect at once and do not raise busy.
module euler_rotate_translate_point_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [31:0] req_point_x,
   input  wire logic [31:0] req_point_y,
   input  wire logic [31:0] req_point_z,
   output logic             rsp_valid,
   output logic [31:0]      rsp_out_x,
   output logic [31:0]      rsp_out_y,
   output logic [31:0]      rsp_out_z,
   output logic             rsp_saturated,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   ert_pkg::angles_type                angle_ff, angle_in;
   logic [2:0][ert_pkg::COORD_W-1:0]   pivot_ff, pivot_in;
   logic                               csr_wr;
   logic                               kick;
   ert_pkg::matrix_type                matrix;
   logic [2:0][ert_pkg::COORD_W-1:0]   point;
   logic [2:0][ert_pkg::COORD_W-1:0]   out_coord;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   always_comb begin
      angle_in = angle_ff;
      pivot_in = pivot_ff;
      kick     = 1'b0;
      if (csr_wr) begin
         unique case (ert_pkg::csr_idx_type'(csr_index))
            ert_pkg::CSR_ANGLE_X: begin angle_in[0] = csr_data[15:0]; kick = 1'b1; end
            ert_pkg::CSR_ANGLE_Y: begin angle_in[1] = csr_data[15:0]; kick = 1'b1; end
            ert_pkg::CSR_ANGLE_Z: begin angle_in[2] = csr_data[15:0]; kick = 1'b1; end
            ert_pkg::CSR_PIVOT_X: pivot_in[0] = csr_data;
            ert_pkg::CSR_PIVOT_Y: pivot_in[1] = csr_data;
            ert_pkg::CSR_PIVOT_Z: pivot_in[2] = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff <= '0;
         pivot_ff <= '0;
      end else begin
         angle_ff <= angle_in;
         pivot_ff <= pivot_in;
      end
   end

   ert_coef u_coef (
      .clock  (clock),
      .reset  (reset),
      .kick   (kick),
      .angles (angle_ff),
      .busy   (busy),
      .matrix (matrix)
   );

   assign point[0] = req_point_x;
   assign point[1] = req_point_y;
   assign point[2] = req_point_z;

   ert_xform u_xform (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .point     (point),
      .pivot     (pivot_ff),
      .matrix    (matrix),
      .out_valid (rsp_valid),
      .out_coord (out_coord),
      .out_sat   (rsp_saturated)
   );

   assign rsp_out_x = out_coord[0];
   assign rsp_out_y = out_coord[1];
   assign rsp_out_z = out_coord[2];

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_valid)
      else $error("accepted word did not come out after four cycles");

   a_sat_clamped: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |->
         (rsp_out_x == 32'h7fffffff || rsp_out_x == 32'h80000000 ||
          rsp_out_y == 32'h7fffffff || rsp_out_y == 32'h80000000 ||
          rsp_out_z == 32'h7fffffff || rsp_out_z == 32'h80000000))
      else $error("saturated flag without a clamped coordinate");

   a_angle_busy: assert property (@(posedge clock) disable iff (reset)
      (csr_wr && (csr_index == ert_pkg::CSR_ANGLE_X || csr_index == ert_pkg::CSR_ANGLE_Y ||
                  csr_index == ert_pkg::CSR_ANGLE_Z)) |=> busy)
      else $error("angle write did not start a matrix update");

endmodule
`default_nettype wire
